/* design/csr_pkg.sv */
// Shared types and codes for the compressed-sparse-row matrix store.
// Used by csr_ctrl and sparse_matrix_csr_store_core; no dependencies.
package csr_pkg;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } csr_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_DN_RD,
    S_DN_WR,
    S_UP_RD,
    S_UP_WR,
    S_WRITE_K,
    S_DONE
  } csr_state_e;

  typedef struct packed {
    logic [31:0] value;
    csr_status_e status;
  } csr_result_t;

endpackage

/* design/csr_mem.sv */
// Entry memory: one write port, one read port, registered read data.
// No package dependencies.
module csr_mem #(
  parameter int Depth = 256,
  parameter int Width = 52
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

/* design/csr_ctrl.sv */
// Access sequencer: scans the sorted entry memory, then reads, updates, inserts or deletes.
// Depends on csr_pkg; drives csr_mem.
module csr_ctrl
  import csr_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_DIM     = 1024,
  parameter int VALUE_BITS  = 32,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1),
  localparam int EW = 20 + VALUE_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           in_cmd_i,
  input  logic [9:0]     in_row_i,
  input  logic [9:0]     in_col_i,
  input  logic [31:0]    in_value_i,
  input  logic [10:0]    row_count_i,
  input  logic [10:0]    column_count_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output csr_result_t    res_o,
  output logic           mem_wr_en_o,
  output logic [AW-1:0]  mem_wr_addr_o,
  output logic [EW-1:0]  mem_wr_data_o,
  output logic [AW-1:0]  mem_rd_addr_o,
  input  logic [EW-1:0]  mem_rd_data_i
);

  csr_state_e state_q, state_d;
  logic [CW-1:0] k_q, k_d, p_q, p_d, count_q, count_d;
  logic found_q, found_d, cmd_q, cmd_d;
  logic [9:0] r_q, r_d, c_q, c_d;
  logic [VALUE_BITS-1:0] wv_q, wv_d, hit_q, hit_d;
  csr_result_t res_q, res_d;

  logic signed [63:0] in_ext, hit_ext;
  logic [VALUE_BITS-1:0] in_val;
  logic [19:0] ent_key;
  logic oor, key_ge, full, wv_zero;
  logic [CW-1:0] p_inc, p_dec;

  assign in_ext  = 64'(signed'(in_value_i));
  assign in_val  = in_ext[VALUE_BITS-1:0];
  assign hit_ext = 64'(signed'(hit_q));
  assign ent_key = mem_rd_data_i[EW-1 -: 20];
  assign key_ge  = ent_key >= {r_q, c_q};
  assign full    = count_q == CW'(MAX_ENTRIES);
  assign wv_zero = wv_q == '0;
  assign p_inc   = p_q + CW'(1);
  assign p_dec   = p_q - CW'(1);
  assign oor = ({1'b0, in_row_i} >= row_count_i) || ({1'b0, in_col_i} >= column_count_i)
            || (32'(in_row_i) >= 32'(MAX_DIM)) || (32'(in_col_i) >= 32'(MAX_DIM));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = oor ? S_DONE : S_SCAN_RD;
      end
      S_SCAN_RD:  state_d = (k_q >= count_q) ? S_DECIDE : S_SCAN_CMP;
      S_SCAN_CMP: state_d = key_ge ? S_DECIDE : S_SCAN_RD;
      S_DECIDE: begin
        if (cmd_q == CMD_READ) state_d = S_DONE;
        else if (found_q) state_d = wv_zero ? S_DN_RD : S_WRITE_K;
        else if (wv_zero || full) state_d = S_DONE;
        else state_d = S_UP_RD;
      end
      S_DN_RD:   state_d = (p_inc < count_q) ? S_DN_WR : S_DONE;
      S_DN_WR:   state_d = S_DN_RD;
      S_UP_RD:   state_d = (p_q > k_q) ? S_UP_WR : S_WRITE_K;
      S_UP_WR:   state_d = S_UP_RD;
      S_WRITE_K: state_d = S_DONE;
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = state_q == S_IDLE;
    res_valid_o   = state_q == S_DONE;
    res_o         = res_q;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = p_q[AW-1:0];
    mem_wr_data_o = mem_rd_data_i;
    mem_rd_addr_o = k_q[AW-1:0];
    unique case (state_q)
      S_DN_RD: mem_rd_addr_o = p_inc[AW-1:0];
      S_UP_RD: mem_rd_addr_o = p_dec[AW-1:0];
      S_DN_WR, S_UP_WR: mem_wr_en_o = 1'b1;
      S_WRITE_K: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = k_q[AW-1:0];
        mem_wr_data_o = {r_q, c_q, wv_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    k_d = k_q; p_d = p_q; count_d = count_q; found_d = found_q; cmd_d = cmd_q;
    r_d = r_q; c_d = c_q; wv_d = wv_q; hit_d = hit_q; res_d = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = in_cmd_i; r_d = in_row_i; c_d = in_col_i; wv_d = in_val;
          k_d = '0; found_d = 1'b0;
          res_d = '{value: 32'd0, status: oor ? ST_RANGE : ST_OK};
        end
      end
      S_SCAN_CMP: begin
        if (key_ge) begin
          found_d = ent_key == {r_q, c_q};
          hit_d   = mem_rd_data_i[VALUE_BITS-1:0];
        end else begin
          k_d = k_q + CW'(1);
        end
      end
      S_DECIDE: begin
        res_d.value = found_q ? hit_ext[31:0] : 32'd0;
        if (cmd_q == CMD_WRITE && !found_q && !wv_zero && full) res_d.status = ST_FULL;
        p_d = found_q ? k_q : count_q;
      end
      S_DN_RD: begin
        if (!(p_inc < count_q)) count_d = count_q - CW'(1);
      end
      S_DN_WR: p_d = p_inc;
      S_UP_WR: p_d = p_dec;
      S_WRITE_K: begin
        if (!found_q) count_d = count_q + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; p_q <= p_d; found_q <= found_d; cmd_q <= cmd_d;
    r_q <= r_d; c_q <= c_d; wv_q <= wv_d; hit_q <= hit_d; res_q <= res_d;
  end

endmodule

/* design/sparse_matrix_csr_store_core.sv */
// Top level of the compressed-sparse-row matrix store.
// Depends on csr_pkg, csr_mem and csr_ctrl.
//
// Usage:
//   s_axis carries one access per transaction: tuser is the command (read or
//   write), tdata holds row, column and write value. m_axis returns one result
//   per access: tdata is the read or previous value, tuser the status.
//   The cfg channel sets row_count (index 0) and column_count (index 1); write
//   it only while no access is in flight. It is always ready.
// Sequencing:
//   One access at a time. The scan reads each stored entry (S_SCAN_RD) and
//   compares its key (S_SCAN_CMP) up to the target position; a delete or insert
//   then moves each later entry with a read state and a write state through the
//   entry memory. An out-of-range access skips the scan and the move.
// Reset:
//   The store is empty after reset and the size registers are zero.
// Stall:
//   A finished result waits in an output register; the next access is taken
//   meanwhile and holds in its final step until that register drains.
module sparse_matrix_csr_store_core
  import csr_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_DIM     = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // row_index[9:0], column_index[19:10], write_value[51:20]
  input  logic        s_axis_tuser,   // command[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // result_value[31:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int EW = 20 + VALUE_BITS;

  logic [10:0] row_count_q, column_count_q;
  logic out_valid_q, out_valid_d;
  csr_result_t out_q, res;
  logic res_valid, res_ready;
  logic mem_wr_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [EW-1:0] mem_wr_data, mem_rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= '0;
      column_count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROW_COUNT:    row_count_q    <= cfg_data_i;
        REG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  csr_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_cmd_i      (s_axis_tuser),
    .in_row_i      (s_axis_tdata[9:0]),
    .in_col_i      (s_axis_tdata[19:10]),
    .in_value_i    (s_axis_tdata[51:20]),
    .row_count_i   (row_count_q),
    .column_count_i(column_count_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  csr_mem #(
    .Depth(MAX_ENTRIES),
    .Width(EW)
  ) u_mem (
    .clk_i,
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (res_valid && res_ready) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.value;
  assign m_axis_tuser  = out_q.status;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("access taken while another is in flight");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_RANGE || m_axis_tuser == ST_FULL)
      |-> m_axis_tdata == 32'd0)
    else $error("rejected access returned a nonzero value");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |=> m_axis_tvalid)
    else $error("result lost at output register");

endmodule

/* dv/tb_top.sv */
// Testbench for sparse_matrix_csr_store_core: directed tables, a fill to capacity, then random accesses,
// each result checked against an in-bench model of the row-sorted sparse store.
// Depends on csr_pkg and the design files.
`timescale 1ns / 1ps

module tb_top;
  import csr_pkg::*;

  localparam int NENT = 256;
  localparam int NDIM = 1024;

  typedef struct {
    logic        cmd;
    logic [9:0]  row;
    logic [9:0]  col;
    logic [31:0] wval;
    logic        chk;
    logic [31:0] xval;
    csr_status_e xst;
  } access_t;

  typedef struct {
    logic [31:0] value;
    csr_status_e status;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [10:0] cfg_data_i = '0;

  sparse_matrix_csr_store_core u_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [9:0]  mat_col [NENT];
  logic [31:0] mat_val [NENT];
  int          mat_rs [NDIM + 1];
  int          mat_cnt;
  int          rows_used;
  int          cols_used;

  outcome_t pending_q[$];
  int errors = 0;
  int mismatches = 0;
  int stall_pct = 38;

  function automatic outcome_t predict_access(logic cmd, int r, int c, logic [31:0] wv);
    outcome_t o;
    int s, e, k, p;
    bit hit;
    o.value = '0;
    o.status = ST_OK;
    hit = 0;
    if (r >= (rows_used > NDIM ? NDIM : rows_used) ||
        c >= (cols_used > NDIM ? NDIM : cols_used)) begin
      o.status = ST_RANGE;
      return o;
    end
    s = mat_rs[r];
    e = mat_rs[r + 1];
    if (e > mat_cnt) e = mat_cnt;
    for (k = s; k < e; k++) begin
      if (mat_col[k] >= c) begin
        hit = (mat_col[k] == c);
        break;
      end
    end
    if (k > e) k = e;
    if (cmd == CMD_READ) begin
      if (hit) o.value = mat_val[k];
      return o;
    end
    if (hit) begin
      o.value = mat_val[k];
      if (wv == 0) begin
        for (p = k; p + 1 < mat_cnt; p++) begin
          mat_col[p] = mat_col[p + 1];
          mat_val[p] = mat_val[p + 1];
        end
        mat_cnt--;
        for (p = r + 1; p <= NDIM; p++)
          if (mat_rs[p] > 0) mat_rs[p]--;
      end else begin
        mat_val[k] = wv;
      end
      return o;
    end
    if (wv == 0) return o;
    if (mat_cnt >= NENT) begin
      o.status = ST_FULL;
      return o;
    end
    for (p = mat_cnt; p > k; p--) begin
      mat_col[p] = mat_col[p - 1];
      mat_val[p] = mat_val[p - 1];
    end
    mat_col[k] = c;
    mat_val[k] = wv;
    mat_cnt++;
    for (p = r + 1; p <= NDIM; p++) mat_rs[p]++;
    return o;
  endfunction

  task automatic send_access(access_t a);
    outcome_t o;
    while ($urandom_range(99) < stall_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= a.cmd;
    s_axis_tdata  <= {4'b0, a.wval, a.col, a.row};
    do @(posedge clk_i); while (!s_axis_tready);
    o = predict_access(a.cmd, a.row, a.col, a.wval);
    if (a.chk && (o.value !== a.xval || o.status !== a.xst)) begin
      errors++;
      $display("table row disagrees with model: row %0d col %0d", a.row, a.col);
    end
    pending_q.push_back(o);
  endtask

  task automatic write_reg(logic idx, logic [10:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_ROW_COUNT) rows_used = val;
    else cols_used = val;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_q.size() == 0) begin
          errors++;
          $display("unexpected result: value %h status %0d", m_axis_tdata, m_axis_tuser);
        end else begin
          outcome_t x;
          x = pending_q.pop_front();
          if (m_axis_tdata !== x.value || m_axis_tuser !== x.status) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %h status %0d, got value %h status %0d",
                       x.value, x.status, m_axis_tdata, m_axis_tuser);
          end
        end
      end
    end
  end

  function automatic access_t mk(logic cmd, int r, int c, logic [31:0] wv,
                                 logic chk = 0, logic [31:0] xv = 0,
                                 csr_status_e xs = ST_OK);
    access_t a;
    a.cmd = cmd; a.row = 10'(r); a.col = 10'(c); a.wval = wv;
    a.chk = chk; a.xval = xv; a.xst = xs;
    return a;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    access_t dir_tab[$];
    int n, i, r, c;
    int lim;
    logic cmd;

    foreach (mat_rs[j]) mat_rs[j] = 0;
    mat_cnt = 0;
    rows_used = 0;
    cols_used = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero-sized matrix: every access is out of range
    dir_tab.push_back(mk(CMD_READ, 0, 0, 0, 1, 0, ST_RANGE));
    dir_tab.push_back(mk(CMD_WRITE, 0, 0, 5, 1, 0, ST_RANGE));
    foreach (dir_tab[j]) send_access(dir_tab[j]);
    drain();
    dir_tab.delete();

    write_reg(REG_ROW_COUNT, 11'd2047);
    write_reg(REG_COLUMN_COUNT, 11'd1024);
    dir_tab.push_back(mk(CMD_READ, 1023, 1023, 0, 1, 0, ST_OK));
    dir_tab.push_back(mk(CMD_WRITE, 1023, 1023, 32'h8000_0000, 1, 0, ST_OK));
    dir_tab.push_back(mk(CMD_READ, 1023, 1023, 0, 1, 32'h8000_0000, ST_OK));
    dir_tab.push_back(mk(CMD_WRITE, 0, 0, 32'h7fff_ffff, 1, 0, ST_OK));
    dir_tab.push_back(mk(CMD_WRITE, 0, 5, 32'hffff_ffff, 1, 0, ST_OK));
    dir_tab.push_back(mk(CMD_WRITE, 0, 2, 32'h1234_5678, 1, 0, ST_OK));
    dir_tab.push_back(mk(CMD_READ, 0, 5, 0, 1, 32'hffff_ffff, ST_OK));
    dir_tab.push_back(mk(CMD_WRITE, 0, 2, 32'h55aa_aa55));
    dir_tab.push_back(mk(CMD_WRITE, 0, 2, 0, 1, 32'h55aa_aa55, ST_OK));
    dir_tab.push_back(mk(CMD_WRITE, 0, 3, 0, 1, 0, ST_OK));
    dir_tab.push_back(mk(CMD_READ, 0, 2, 0, 1, 0, ST_OK));
    dir_tab.push_back(mk(CMD_WRITE, 512, 341, 32'haaaa_5555));
    dir_tab.push_back(mk(CMD_READ, 512, 341, 0));
    dir_tab.push_back(mk(CMD_WRITE, 0, 0, 0, 1, 32'h7fff_ffff, ST_OK));
    foreach (dir_tab[j]) send_access(dir_tab[j]);
    drain();
    dir_tab.delete();

    write_reg(REG_ROW_COUNT, 11'd1);
    write_reg(REG_COLUMN_COUNT, 11'd1);
    dir_tab.push_back(mk(CMD_READ, 1, 0, 0, 1, 0, ST_RANGE));
    dir_tab.push_back(mk(CMD_READ, 0, 1, 0, 1, 0, ST_RANGE));
    dir_tab.push_back(mk(CMD_READ, 1023, 1023, 0, 1, 0, ST_RANGE));
    dir_tab.push_back(mk(CMD_WRITE, 0, 0, 32'h0000_0001, 1, 0, ST_OK));
    foreach (dir_tab[j]) send_access(dir_tab[j]);
    drain();

    // fill the store to capacity, then probe the full case
    write_reg(REG_ROW_COUNT, 11'd16);
    write_reg(REG_COLUMN_COUNT, 11'd32);
    stall_pct = 0;
    for (i = 0; i < 300; i++)
      send_access(mk(CMD_WRITE, i / 32, i % 32, $urandom() | 1));
    send_access(mk(CMD_READ, $urandom_range(15), $urandom_range(31), 0));
    drain();
    stall_pct = 38;

    // random phases; small sizes keep collisions frequent, large ones reach far bits
    for (n = 0; n < 6; n++) begin
      case (n)
        0: begin write_reg(REG_ROW_COUNT, 11'd8);    write_reg(REG_COLUMN_COUNT, 11'd8);    end
        1: begin write_reg(REG_ROW_COUNT, 11'd1024); write_reg(REG_COLUMN_COUNT, 11'd1024); end
        2: begin write_reg(REG_ROW_COUNT, 11'd4);     write_reg(REG_COLUMN_COUNT, 11'd64);   end
        3: begin write_reg(REG_ROW_COUNT, 11'd64);    write_reg(REG_COLUMN_COUNT, 11'd2047); end
        4: begin write_reg(REG_ROW_COUNT, 11'd0);     write_reg(REG_COLUMN_COUNT, 11'd16);   end
        default: begin write_reg(REG_ROW_COUNT, 11'd24); write_reg(REG_COLUMN_COUNT, 11'd24); end
      endcase
      lim = (rows_used > NDIM ? NDIM : rows_used);
      for (i = 0; i < 250; i++) begin
        stall_pct = (i >= 100 && i < 160) ? 0 : 38;
        cmd = $urandom_range(99) < 55;
        if ($urandom_range(9) == 0 || lim == 0) begin
          r = $urandom_range(1023);
          c = $urandom_range(1023);
        end else begin
          r = $urandom_range(lim - 1);
          c = $urandom_range((cols_used > NDIM ? NDIM : cols_used) - 1);
        end
        send_access(mk(cmd, r, c, rand_value()));
        if (i == 200) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
